// File: rtl/core/atp_pkg.sv
// Shared types and codes for the audio/video timestamp pairer.
// No dependencies; imported by every module of the block.
package atp_pkg;

    localparam logic [1:0] MODE_AUDIO = 2'd0;
    localparam logic [1:0] MODE_VIDEO = 2'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] stamp;
        logic [31:0] block_ref;
        logic [31:0] offset;
    } item_t;

    typedef struct packed {
        logic        video_present;
        logic [31:0] video_block;
        logic [31:0] video_offset;
        logic        audio_present;
        logic [31:0] audio_block;
        logic [31:0] audio_offset;
        logic        final_res;
    } result_t;

    // message handle and kind, as queued between front and back end
    typedef struct packed {
        logic        is_video;
        logic [31:0] block_ref;
        logic [31:0] offset;
    } handle_t;

endpackage

// File: rtl/core/av_timestamp_pairer_unit.sv
// Top level of the audio/video timestamp pairer: front end, queue, back end.
// Depends on atp_pkg, atp_front, atp_queue and atp_back.
//
//  channel   signals                              direction
//  item      item_valid, item_stall, item         input transactions
//  result    result_valid, result_stall, result   output transactions
//  config    cfg_wr_en, cfg_wr_data               passthrough register
//
// The front end takes one transaction per cycle while the two-entry queue has
// room. The back end works through each queued message in steps, emitting at
// most one result per step; a message that is only stored in its slot emits none.
// Results leave through one output register; a stall holds it and the back end.
// Reset empties the queue, both slots and the output register; passthrough is 0.
module av_timestamp_pairer_unit
    import atp_pkg::*;
#(
    parameter int STAMP_WIDTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data
);

    logic                   passthrough_reg;
    logic                   q_full;
    logic                   push;
    handle_t                push_handle;
    logic [STAMP_WIDTH-1:0] push_stamp;
    logic                   pop;
    logic                   head_valid;
    handle_t                head_handle;
    logic [STAMP_WIDTH-1:0] head_stamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passthrough_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            passthrough_reg <= cfg_wr_data;
        end
    end

    atp_front #(.STAMP_WIDTH(STAMP_WIDTH)) u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .q_full      (q_full),
        .push        (push),
        .push_handle (push_handle),
        .push_stamp  (push_stamp)
    );

    atp_queue #(.STAMP_WIDTH(STAMP_WIDTH)) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_handle (push_handle),
        .push_stamp  (push_stamp),
        .full        (q_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_handle (head_handle),
        .head_stamp  (head_stamp)
    );

    atp_back #(.STAMP_WIDTH(STAMP_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .passthrough  (passthrough_reg),
        .head_valid   (head_valid),
        .head_handle  (head_handle),
        .head_stamp   (head_stamp),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/core/atp_front.sv
// Front end: accepts input transactions, drops unrecognized kinds and
// pushes audio/video messages into the queue. Depends on atp_pkg.
module atp_front
    import atp_pkg::*;
#(
    parameter int STAMP_WIDTH = 64
)
(
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    input  logic                   q_full,
    output logic                   push,
    output handle_t                push_handle,
    output logic [STAMP_WIDTH-1:0] push_stamp
);

    logic known;

    always_comb
    begin
        known              = item.mode inside {MODE_AUDIO, MODE_VIDEO};
        item_stall         = q_full;
        push               = item_valid && !q_full && known;
        push_handle.is_video  = (item.mode == MODE_VIDEO);
        push_handle.block_ref = item.block_ref;
        push_handle.offset    = item.offset;
        push_stamp         = item.stamp[STAMP_WIDTH-1:0];
    end

endmodule

// File: rtl/core/atp_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on atp_pkg for the queued handle type.
module atp_queue
    import atp_pkg::*;
#(
    parameter int STAMP_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  handle_t                push_handle,
    input  logic [STAMP_WIDTH-1:0] push_stamp,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output handle_t                head_handle,
    output logic [STAMP_WIDTH-1:0] head_stamp
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    handle_t                handle_reg [DEPTH];
    logic [STAMP_WIDTH-1:0] stamp_reg  [DEPTH];
    logic [PW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == CW'(DEPTH));
        head_valid  = (count_reg != '0);
        head_handle = handle_reg[rd_ptr_reg];
        head_stamp  = stamp_reg[rd_ptr_reg];
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            handle_reg[wr_ptr_reg] <= push_handle;
            stamp_reg[wr_ptr_reg]  <= push_stamp;
        end
    end

endmodule

// File: rtl/core/atp_back.sv
// Back end: pending audio/video slots, pairing sequencer and output register.
// Takes one queued message at a time; depends on atp_pkg.
module atp_back
    import atp_pkg::*;
#(
    parameter int STAMP_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   passthrough,
    input  logic                   head_valid,
    input  handle_t                head_handle,
    input  logic [STAMP_WIDTH-1:0] head_stamp,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    logic                   vheld_reg, vheld_next;
    logic                   aheld_reg, aheld_next;
    logic [STAMP_WIDTH-1:0] vstamp_reg, vstamp_next;
    logic [STAMP_WIDTH-1:0] astamp_reg, astamp_next;
    logic [31:0]            vblock_reg, vblock_next;
    logic [31:0]            voffset_reg, voffset_next;
    logic [31:0]            ablock_reg, ablock_next;
    logic [31:0]            aoffset_reg, aoffset_next;
    // second step pending: both slots full, compare still to do
    logic                   phase_reg, phase_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic                   out_can;
    logic                   step;
    logic                   emit;
    logic                   same_held;
    logic                   other_held;
    logic [STAMP_WIDTH-1:0] cmp_v, cmp_a;
    logic [31:0]            cv_block, cv_offset, ca_block, ca_offset;
    result_t                res;

    always_comb
    begin
        out_can = !out_valid_reg || !result_stall;
        step    = head_valid && out_can;

        same_held  = head_handle.is_video ? vheld_reg : aheld_reg;
        other_held = head_handle.is_video ? aheld_reg : vheld_reg;

        // compare operands: the new message stands in for its own slot
        // when it has not been installed yet
        cmp_v     = (!phase_reg && head_handle.is_video) ? head_stamp : vstamp_reg;
        cv_block  = (!phase_reg && head_handle.is_video) ? head_handle.block_ref : vblock_reg;
        cv_offset = (!phase_reg && head_handle.is_video) ? head_handle.offset : voffset_reg;
        cmp_a     = (!phase_reg && !head_handle.is_video) ? head_stamp : astamp_reg;
        ca_block  = (!phase_reg && !head_handle.is_video) ? head_handle.block_ref : ablock_reg;
        ca_offset = (!phase_reg && !head_handle.is_video) ? head_handle.offset : aoffset_reg;

        vheld_next   = vheld_reg;
        aheld_next   = aheld_reg;
        vstamp_next  = vstamp_reg;
        astamp_next  = astamp_reg;
        vblock_next  = vblock_reg;
        voffset_next = voffset_reg;
        ablock_next  = ablock_reg;
        aoffset_next = aoffset_reg;
        phase_next   = phase_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        res          = '0;

        if (step)
        begin
            if (passthrough)
            begin
                emit = 1'b1;
                if (vheld_reg)
                begin
                    res.video_present = 1'b1;
                    res.video_block   = vblock_reg;
                    res.video_offset  = voffset_reg;
                    vheld_next        = 1'b0;
                end
                else if (aheld_reg)
                begin
                    res.audio_present = 1'b1;
                    res.audio_block   = ablock_reg;
                    res.audio_offset  = aoffset_reg;
                    aheld_next        = 1'b0;
                end
                else
                begin
                    res.video_present = head_handle.is_video;
                    res.video_block   = head_handle.is_video ? head_handle.block_ref : '0;
                    res.video_offset  = head_handle.is_video ? head_handle.offset : '0;
                    res.audio_present = !head_handle.is_video;
                    res.audio_block   = head_handle.is_video ? '0 : head_handle.block_ref;
                    res.audio_offset  = head_handle.is_video ? '0 : head_handle.offset;
                    res.final_res     = 1'b1;
                    pop               = 1'b1;
                end
            end
            else if (!phase_reg && same_held)
            begin
                // flush the slot of the same kind, then install the new one
                emit = 1'b1;
                if (head_handle.is_video)
                begin
                    res.video_present = 1'b1;
                    res.video_block   = vblock_reg;
                    res.video_offset  = voffset_reg;
                    vstamp_next       = head_stamp;
                    vblock_next       = head_handle.block_ref;
                    voffset_next      = head_handle.offset;
                end
                else
                begin
                    res.audio_present = 1'b1;
                    res.audio_block   = ablock_reg;
                    res.audio_offset  = aoffset_reg;
                    astamp_next       = head_stamp;
                    ablock_next       = head_handle.block_ref;
                    aoffset_next      = head_handle.offset;
                end
                res.final_res = !other_held;
                phase_next    = other_held;
                pop           = !other_held;
            end
            else
            begin
                // install (first step) or both slots already full
                if (!phase_reg)
                begin
                    if (head_handle.is_video)
                    begin
                        vheld_next   = 1'b1;
                        vstamp_next  = head_stamp;
                        vblock_next  = head_handle.block_ref;
                        voffset_next = head_handle.offset;
                    end
                    else
                    begin
                        aheld_next   = 1'b1;
                        astamp_next  = head_stamp;
                        ablock_next  = head_handle.block_ref;
                        aoffset_next = head_handle.offset;
                    end
                end
                pop        = 1'b1;
                phase_next = 1'b0;
                if (phase_reg || other_held)
                begin
                    emit          = 1'b1;
                    res.final_res = 1'b1;
                    if (cmp_v <= cmp_a)
                    begin
                        res.video_present = 1'b1;
                        res.video_block   = cv_block;
                        res.video_offset  = cv_offset;
                        vheld_next        = 1'b0;
                    end
                    if (cmp_a <= cmp_v)
                    begin
                        res.audio_present = 1'b1;
                        res.audio_block   = ca_block;
                        res.audio_offset  = ca_offset;
                        aheld_next        = 1'b0;
                    end
                end
            end
        end

        out_valid_next = out_can ? emit : out_valid_reg;
        out_next       = (out_can && emit) ? res : out_reg;
        result_valid   = out_valid_reg;
        result         = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vheld_reg     <= 1'b0;
            aheld_reg     <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vheld_reg     <= vheld_next;
            aheld_reg     <= aheld_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vstamp_reg  <= vstamp_next;
        astamp_reg  <= astamp_next;
        vblock_reg  <= vblock_next;
        voffset_reg <= voffset_next;
        ablock_reg  <= ablock_next;
        aoffset_reg <= aoffset_next;
        out_reg     <= out_next;
    end

endmodule

// File: rtl/core/atp_checker.sv
// Port-level checks on the result channel of the pairer, bound to the top.
// Depends on atp_pkg and av_timestamp_pairer_unit.
module atp_checker
    import atp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // every result carries at least one message
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.video_present || result.audio_present))
        else $error("result without any message");

    // an absent video half reads as zero
    a_zero_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.video_present && !result.audio_present) == 1'b0 &&
        (result_valid && !result.video_present) |->
        (result.video_block == '0 && result.video_offset == '0))
        else $error("absent video half not zero");

    // a matched pair always ends its message's results
    a_pair_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.video_present && result.audio_present) |->
        result.final_res)
        else $error("paired result not final");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result dropped or changed");

endmodule

bind av_timestamp_pairer_unit atp_checker u_atp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
